FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Each one samples on the rising edge of clk
// and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds on every clock edge outside reset.
`define CHECK_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a consequent holds whenever its antecedent does, in the same cycle.
`define CHECK_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/mpq_pkg.sv
package mpq_pkg;

	localparam int DATA_W = 32;
	localparam int OCC_W  = 5;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_POP    = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic        [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] prio;
	} mpq_entry_t;

	// Command broadcast to every cell of the chain in the same cycle.
	typedef struct packed {
		logic       ins;
		logic       pop;
		mpq_entry_t entry;
	} mpq_cmd_t;

endpackage

FILE: rtl/core/mpq_cell.sv
module mpq_cell (
	input  logic               clk,
	input  mpq_pkg::mpq_cmd_t  cmd,
	input  logic               occupied,
	input  logic               left_take,
	input  mpq_pkg::mpq_entry_t left_data,
	input  mpq_pkg::mpq_entry_t right_data,
	output logic               take,
	output mpq_pkg::mpq_entry_t data
);
	import mpq_pkg::*;

	mpq_entry_t data_q;

	// A cell takes part in an insert when it is empty or holds a strictly larger
	// priority number; the chain stays sorted, so these cells form a tail.
	always_comb begin
		take = !occupied || ($signed(data_q.prio) > $signed(cmd.entry.prio));
		data = data_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (left_take) begin
				data_q <= left_data;
			end else if (take) begin
				data_q <= cmd.entry;
			end
		end else if (cmd.pop) begin
			data_q <= right_data;
		end
	end

endmodule

FILE: rtl/core/min_priority_queue.sv
// Sorted priority queue built as a chain of compare-and-shift cells.
// The result of an item is registered and appears on m_tdata in the cycle after acceptance.
// One item per cycle while s_tready is high; all cells check the new priority in parallel.
// s_tready stays high while the output register is empty or being drained.
// Reset empties the queue and the output register; cell storage is not cleared.
`include "assert_macros.svh"

module min_priority_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // item_value [31:0], item_priority [63:32]
	input  logic        s_tuser,  // action [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // popped_value [31:0], occupancy [36:32], zero fill
	output logic [1:0]  m_tuser   // status [1:0]
);
	import mpq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [CW-1:0] count_q;
	mpq_cmd_t      cmd;
	logic          accept;
	logic          is_pop;
	logic          full;
	logic          empty;
	status_t       status;
	logic [CW-1:0] count_next;

	logic       [QUEUE_DEPTH-1:0] occ;
	logic       [QUEUE_DEPTH-1:0] take;
	mpq_entry_t                   cell_data [QUEUE_DEPTH];

	logic              m_valid_q;
	logic [DATA_W-1:0] popped_q;
	logic [OCC_W-1:0]  occ_q;
	status_t           status_q;

	assign accept = s_tvalid && s_tready;
	assign is_pop = (s_tuser == ACT_POP);
	assign full   = (count_q == CW'(QUEUE_DEPTH));
	assign empty  = (count_q == '0);

	always_comb begin
		cmd.ins         = accept && !is_pop && !full;
		cmd.pop         = accept && is_pop && !empty;
		cmd.entry.value = s_tdata[31:0];
		cmd.entry.prio  = s_tdata[63:32];
		status          = ST_DONE;
		if (is_pop && empty) begin
			status = ST_EMPTY;
		end else if (!is_pop && full) begin
			status = ST_FULL;
		end
		count_next = count_q;
		if (cmd.ins) begin
			count_next = count_q + 1'b1;
		end else if (cmd.pop) begin
			count_next = count_q - 1'b1;
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		assign occ[i] = (count_q > CW'(i));
		if (i == 0) begin : g_head
			mpq_cell u_cell (
				.clk        (clk),
				.cmd        (cmd),
				.occupied   (occ[i]),
				.left_take  (1'b0),
				.left_data  ('0),
				.right_data (cell_data[i+1]),
				.take       (take[i]),
				.data       (cell_data[i])
			);
		end else if (i == QUEUE_DEPTH - 1) begin : g_tail
			mpq_cell u_cell (
				.clk        (clk),
				.cmd        (cmd),
				.occupied   (occ[i]),
				.left_take  (take[i-1]),
				.left_data  (cell_data[i-1]),
				.right_data ('0),
				.take       (take[i]),
				.data       (cell_data[i])
			);
		end else begin : g_mid
			mpq_cell u_cell (
				.clk        (clk),
				.cmd        (cmd),
				.occupied   (occ[i]),
				.left_take  (take[i-1]),
				.left_data  (cell_data[i-1]),
				.right_data (cell_data[i+1]),
				.take       (take[i]),
				.data       (cell_data[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			popped_q <= cmd.pop ? cell_data[0].value : '0;
			occ_q    <= OCC_W'(count_next);
			status_q <= status;
		end
	end

	assign s_tready = !m_valid_q || m_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, occ_q, popped_q};
	assign m_tuser  = status_q;

	`CHECK_ALWAYS(a_count_bound, count_q <= CW'(QUEUE_DEPTH), "entry count above depth")
	`CHECK_NEXT(a_insert_grows, cmd.ins, count_q == $past(count_q) + 1'b1, "insert lost")
	`CHECK_IMPLIES(a_head_sorted, count_q >= CW'(2),
		$signed(cell_data[0].prio) <= $signed(cell_data[1].prio), "head out of order")
	`CHECK_IMPLIES(a_empty_zero, m_valid_q && status_q == ST_EMPTY,
		occ_q == '0 && popped_q == '0, "refused pop reports data")

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import mpq_pkg::*;

	localparam int DEPTH       = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PRINT_LIMIT = 60;

	localparam int PRIO_MAX = 32'sh7FFF_FFFF;
	localparam int PRIO_MIN = 32'sh8000_0000;

	typedef enum int {
		SINK_FREE,
		SINK_CHOPPY
	} sink_mode_t;

	typedef struct {
		logic [31:0] popped;
		status_t     status;
		logic [4:0]  occupancy;
	} queue_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;

	// Shadow copy of the sorted queue, front entry at index 0.
	logic [31:0] shadow_values[DEPTH];
	int          shadow_prios[DEPTH];
	int          shadow_count = 0;

	queue_result_t pending_results[$];
	int            error_count = 0;
	int            cycle_count = 0;

	// Sender and receiver pacing.
	bit         source_gaps = 1'b0;
	int         burst_left = 0;
	sink_mode_t sink_mode = SINK_FREE;
	int         hold_request = 0;

	min_priority_queue #(.QUEUE_DEPTH(DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		error_count++;
		if (error_count <= PRINT_LIMIT)
			$display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
	endtask

	// Applies one accepted item to the shadow queue and records its result.
	task automatic predict_item(action_t act, logic [31:0] value, int prio);
		queue_result_t res;
		int            pos;
		res.popped = '0;
		res.status = ST_DONE;
		if (act == ACT_INSERT) begin
			if (shadow_count >= DEPTH) begin
				res.status = ST_FULL;
			end else begin
				// Walk in from the back; equal priorities stay ahead of the new entry.
				pos = shadow_count;
				while (pos > 0 && shadow_prios[pos-1] > prio) begin
					shadow_values[pos] = shadow_values[pos-1];
					shadow_prios[pos]  = shadow_prios[pos-1];
					pos--;
				end
				shadow_values[pos] = value;
				shadow_prios[pos]  = prio;
				shadow_count++;
			end
		end else begin
			if (shadow_count == 0) begin
				res.status = ST_EMPTY;
			end else begin
				res.popped = shadow_values[0];
				for (int i = 1; i < shadow_count; i++) begin
					shadow_values[i-1] = shadow_values[i];
					shadow_prios[i-1]  = shadow_prios[i];
				end
				shadow_count--;
			end
		end
		res.occupancy = shadow_count[4:0];
		pending_results.push_back(res);
	endtask

	// Offers one item and returns once it has been taken. The valid line stays
	// high across a burst and, when source_gaps is set, drops for a random gap between bursts.
	task automatic send_item(action_t act, logic [31:0] value, logic [31:0] prio);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {prio, value};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_item(act, value, prio);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (source_gaps) begin
				gap = $urandom_range(1, 5);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	function automatic logic [31:0] pick_priority();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom_range(0, 8) - 4;
			4: begin
				case ($urandom_range(0, 5))
					0: return PRIO_MIN;
					1: return PRIO_MIN + 1;
					2: return PRIO_MAX;
					3: return PRIO_MAX - 1;
					4: return -1;
					default: return 0;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_value();
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
		return $urandom;
	endfunction

	task automatic send_random(int insert_pct);
		if ($urandom_range(1, 100) <= insert_pct)
			send_item(ACT_INSERT, pick_value(), pick_priority());
		else
			send_item(ACT_POP, $urandom, $urandom);
	endtask

	// Pop on empty, a full queue of extreme and tied priorities, an insert
	// refused when full, then a few pops to see the order come out.
	task automatic test_directed();
		int          prios[DEPTH] = '{PRIO_MAX, PRIO_MIN, 0, -1, 5, 5, 5, PRIO_MIN,
			PRIO_MAX, 0, -1, 5, 1, 1, PRIO_MIN + 1, PRIO_MAX - 1};
		logic [31:0] values[DEPTH] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
			32'h1, 32'h2, 32'h3, 32'h11, 32'h22, 32'h33, 32'h44, 32'h4,
			32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0F0F_F0F0, 32'hF0F0_0F0F};
		source_gaps = 1'b0;
		sink_mode   = SINK_FREE;
		send_item(ACT_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		for (int i = 0; i < DEPTH; i++)
			send_item(ACT_INSERT, values[i], prios[i]);
		send_item(ACT_INSERT, 32'hDEAD_BEEF, PRIO_MIN);
		repeat (5) send_item(ACT_POP, 32'h0, 32'h0);
	endtask

	task automatic test_random_mix(int count);
		source_gaps = 1'b1;
		sink_mode   = SINK_CHOPPY;
		repeat (count) send_random(55);
	endtask

	// Swing the queue between full and empty so both refusals come up often.
	task automatic test_fill_drain(int rounds);
		for (int r = 0; r < rounds; r++) begin
			source_gaps = r[0];
			sink_mode   = r[1] ? SINK_CHOPPY : SINK_FREE;
			repeat (40) send_random(85);
			repeat (40) send_random(15);
		end
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering,
	// so the output register fills and the input stalls.
	task automatic test_backpressure(int count);
		source_gaps  = 1'b0;
		sink_mode    = SINK_FREE;
		hold_request = 150;
		repeat (count) send_random(60);
	endtask

	initial begin : sink_pacing
		int run_left;
		int hold_left;
		bit run_ready;
		run_left  = 0;
		hold_left = 0;
		run_ready = 1'b1;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (sink_mode == SINK_FREE) begin
				m_tready <= 1'b1;
			end else begin
				if (run_left == 0) begin
					run_ready = ~run_ready;
					run_left  = run_ready ? $urandom_range(1, 10) : $urandom_range(1, 6);
				end
				run_left--;
				m_tready <= run_ready;
			end
		end
	end

	initial begin : result_checker
		queue_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected item", m_tdata[31:0], '0);
				end else begin
					want = pending_results.pop_front();
					if (m_tdata[31:0] !== want.popped)
						report_mismatch("popped_value", m_tdata[31:0], want.popped);
					if (m_tuser !== want.status)
						report_mismatch("status", m_tuser, want.status);
					if (m_tdata[36:32] !== want.occupancy)
						report_mismatch("occupancy", m_tdata[36:32], want.occupancy);
				end
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_random_mix(500);
		test_fill_drain(8);
		test_backpressure(150);

		s_tvalid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/mpq_pkg.sv
rtl/core/mpq_cell.sv
rtl/core/min_priority_queue.sv
sim/tb_top.sv
